// ===== rtl/client_table_with_aging_unit_assert.svh =====
// Assertion macros used by the checker module of the client table.
`ifndef CLIENT_TABLE_WITH_AGING_UNIT_ASSERT_SVH
`define CLIENT_TABLE_WITH_AGING_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTAU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("client table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CTAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("client table assertion failed");

`endif

// ===== rtl/ctau_pkg.sv =====
// Types, constants and request codes of the client table with aging.
package ctau_pkg;

    localparam int MAX_CLIENTS_DEF = 16;
    localparam int ADDR_W          = 48;
    localparam int LIFE_W          = 16;
    localparam int REQ_W           = 2;

    localparam logic [LIFE_W-1:0] TIMEOUT_RST = LIFE_W'(100);

    localparam logic [REQ_W-1:0] REQ_REGISTER   = REQ_W'(0);
    localparam logic [REQ_W-1:0] REQ_UNREGISTER = REQ_W'(1);
    localparam logic [REQ_W-1:0] REQ_TICK       = REQ_W'(2);

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              cfg;
        logic [LIFE_W-1:0] life;
    } slot_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/ctau_ifs.sv =====
// Handshake interfaces for the request, response and timeout channels.
interface ctau_req_if import ctau_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [ADDR_W-1:0] client_addr;
    logic              is_cfg;

    modport source(output valid, output req_type, output client_addr, output is_cfg,
                   input ready);
    modport sink(input valid, input req_type, input client_addr, input is_cfg,
                 output ready);
endinterface

interface ctau_rsp_if ();
    logic valid;
    logic ready;
    logic ok;
    logic cfg_present;

    modport source(output valid, output ok, output cfg_present, input ready);
    modport sink(input valid, input ok, input cfg_present, output ready);
endinterface

interface ctau_cfg_if import ctau_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LIFE_W-1:0] connect_timeout;

    modport source(output valid, output connect_timeout, input ready);
    modport sink(input valid, input connect_timeout, output ready);
endinterface

// ===== rtl/ctau_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module ctau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/client_table_with_aging_unit.sv =====
// Client table with aging: register, unregister and tick requests over a slot memory.
// Each request beat is answered by exactly one response beat. The unit sweeps every slot
// of the table through the single read port of the slot memory, one slot per cycle, and
// then commits the update; no new request is accepted until this one's response has
// been loaded into the output register. The response sits in an output register, so a new
// request is taken while an earlier response still waits for the sink. The valid mark
// of each slot lives in flip-flops cleared by reset; the slot memory needs no clearing.
module client_table_with_aging_unit import ctau_pkg::*; #(
    parameter int MAX_CLIENTS = MAX_CLIENTS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ctau_req_if.sink  req,
    ctau_rsp_if.source rsp,
    ctau_cfg_if.sink  cfg
);

    localparam int IDX_W  = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_CLIENTS + 1);
    localparam int SLOT_W = $bits(slot_t);

    state_t state_reg, state_next;

    logic [LIFE_W-1:0]      timeout_reg;
    logic [MAX_CLIENTS-1:0] valid_reg, valid_next;

    logic [REQ_W-1:0]  type_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              is_cfg_reg;

    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;

    logic             cand_found_reg, cand_found_next;
    logic [IDX_W-1:0] cand_idx_reg, cand_idx_next;
    logic             match_found_reg, match_found_next;
    logic [IDX_W-1:0] match_idx_reg, match_idx_next;
    logic             cfg_acc_reg, cfg_acc_next;

    logic res_ok_reg, res_ok_next;
    logic res_cfg_reg, res_cfg_next;

    logic out_valid_reg, out_valid_next;
    logic out_ok_reg, out_ok_next;
    logic out_cfg_reg, out_cfg_next;

    logic              accept;
    logic              out_free;
    logic              scan_end;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    slot_t             mem_wslot;
    logic              mem_re;
    logic [SLOT_W-1:0] mem_rdata;
    slot_t             rd_slot;
    logic              cur_valid;
    logic              cur_match;

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.ok = out_ok_reg;
    assign rsp.cfg_present = out_cfg_reg;

    assign accept = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign scan_end = (rd_cnt_reg == CNT_W'(MAX_CLIENTS)) && !pend_reg;

    assign rd_slot = slot_t'(mem_rdata);
    assign cur_valid = valid_reg[pend_idx_reg];
    assign cur_match = cur_valid && (rd_slot.addr == addr_reg);
    assign mem_re = (state_reg == ST_SCAN) && (rd_cnt_reg != CNT_W'(MAX_CLIENTS));

    ctau_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(MAX_CLIENTS)
    ) u_slot_ram (
        .clk(clk),
        .we(mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wslot),
        .re(mem_re),
        .raddr(rd_cnt_reg[IDX_W-1:0]),
        .rdata(mem_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        rd_cnt_next = rd_cnt_reg;
        pend_next = 1'b0;
        pend_idx_next = pend_idx_reg;
        cand_found_next = cand_found_reg;
        cand_idx_next = cand_idx_reg;
        match_found_next = match_found_reg;
        match_idx_next = match_idx_reg;
        cfg_acc_next = cfg_acc_reg;
        res_ok_next = res_ok_reg;
        res_cfg_next = res_cfg_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_ok_next = out_ok_reg;
        out_cfg_next = out_cfg_reg;
        mem_we = 1'b0;
        mem_waddr = pend_idx_reg;
        mem_wslot = rd_slot;
        case (state_reg)
            ST_IDLE:
            begin
                rd_cnt_next = '0;
                cand_found_next = 1'b0;
                match_found_next = 1'b0;
                cfg_acc_next = 1'b0;
            end
            ST_SCAN:
            begin
                if (mem_re)
                begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                    pend_next = 1'b1;
                    pend_idx_next = rd_cnt_reg[IDX_W-1:0];
                end
                if (pend_reg)
                begin
                    case (type_reg)
                        REQ_REGISTER, REQ_UNREGISTER:
                        begin
                            if ((type_reg == REQ_REGISTER) && (!cur_valid || cur_match)
                                && !cand_found_reg)
                            begin
                                cand_found_next = 1'b1;
                                cand_idx_next = pend_idx_reg;
                            end
                            if (cur_match && !match_found_reg)
                            begin
                                match_found_next = 1'b1;
                                match_idx_next = pend_idx_reg;
                            end
                            if (cur_valid && !cur_match && rd_slot.cfg)
                            begin
                                cfg_acc_next = 1'b1;
                            end
                        end
                        REQ_TICK:
                        begin
                            if (cur_valid && (rd_slot.life != '0))
                            begin
                                mem_we = 1'b1;
                                mem_wslot.life = rd_slot.life - LIFE_W'(1);
                                if (rd_slot.life == LIFE_W'(1))
                                begin
                                    valid_next[pend_idx_reg] = 1'b0;
                                end
                            end
                            if (cur_valid && rd_slot.cfg && (rd_slot.life != LIFE_W'(1)))
                            begin
                                cfg_acc_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (cur_valid && rd_slot.cfg)
                            begin
                                cfg_acc_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_COMMIT:
            begin
                res_ok_next = 1'b0;
                res_cfg_next = cfg_acc_reg;
                case (type_reg)
                    REQ_REGISTER:
                    begin
                        if (match_found_reg)
                        begin
                            valid_next[match_idx_reg] = 1'b0;
                        end
                        if (cand_found_reg)
                        begin
                            valid_next[cand_idx_reg] = 1'b1;
                            mem_we = 1'b1;
                            mem_waddr = cand_idx_reg;
                            mem_wslot.addr = addr_reg;
                            mem_wslot.cfg = is_cfg_reg;
                            mem_wslot.life = timeout_reg;
                        end
                        res_ok_next = cand_found_reg;
                        res_cfg_next = cfg_acc_reg || (cand_found_reg && is_cfg_reg);
                    end
                    REQ_UNREGISTER:
                    begin
                        if (match_found_reg)
                        begin
                            valid_next[match_idx_reg] = 1'b0;
                        end
                        res_ok_next = match_found_reg;
                    end
                    default:
                    begin
                        res_ok_next = 1'b0;
                    end
                endcase
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next = res_ok_reg;
                    out_cfg_next = res_cfg_reg;
                end
            end
            default:
            begin
                rd_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            timeout_reg <= TIMEOUT_RST;
            valid_reg <= '0;
            pend_reg <= 1'b0;
            rd_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            pend_reg <= pend_next;
            rd_cnt_reg <= rd_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                timeout_reg <= cfg.connect_timeout;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg <= req.req_type;
            addr_reg <= req.client_addr;
            is_cfg_reg <= req.is_cfg;
        end
        pend_idx_reg <= pend_idx_next;
        cand_found_reg <= cand_found_next;
        cand_idx_reg <= cand_idx_next;
        match_found_reg <= match_found_next;
        match_idx_reg <= match_idx_next;
        cfg_acc_reg <= cfg_acc_next;
        res_ok_reg <= res_ok_next;
        res_cfg_reg <= res_cfg_next;
        out_ok_reg <= out_ok_next;
        out_cfg_reg <= out_cfg_next;
    end

endmodule

// ===== rtl/ctau_checker.sv =====
// Port-level checker for the client table with aging, bound to the top level.
`include "client_table_with_aging_unit_assert.svh"

module ctau_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic rsp_ok,
    input logic rsp_cfg_present
);

    logic [1:0] outstanding_reg, outstanding_next;
    logic       req_beat;
    logic       rsp_beat;

    assign req_beat = req_valid && req_ready;
    assign rsp_beat = rsp_valid && rsp_ready;

    always_comb
    begin
        outstanding_next = outstanding_reg + 2'(req_beat) - 2'(rsp_beat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // A response beat always belongs to a request beat taken earlier.
    `CTAU_ASSERT_SAME(a_rsp_has_req, clk, rst_n, rsp_valid, outstanding_reg != 2'd0)
    // At most one request is in work and one response waits.
    `CTAU_ASSERT_SAME(a_outstanding_bound, clk, rst_n, 1'b1, outstanding_reg != 2'd3)
    // The table works on one request at a time.
    `CTAU_ASSERT_NEXT(a_one_in_work, clk, rst_n, req_beat, !req_ready)
    `CTAU_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_ok) && $stable(rsp_cfg_present))

endmodule

bind client_table_with_aging_unit ctau_checker u_ctau_checker (
    .clk(clk),
    .rst_n(rst_n),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .rsp_ok(rsp.ok),
    .rsp_cfg_present(rsp.cfg_present)
);

// ===== tb/tb_top.sv =====
// Testbench for the client table with aging: random and directed requests checked beat by beat.
`timescale 1ns / 100ps

module tb_top;
    import ctau_pkg::*;

    localparam int SLOTS = MAX_CLIENTS_DEF;
    localparam int QUIET_LIMIT = 4000;
    localparam int POOL_SIZE = 20;
    localparam logic [REQ_W-1:0] REQ_UNUSED = REQ_W'(3);
    localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};

    typedef struct packed {
        logic ok;
        logic cfg_present;
    } reply_t;

    class client_table_tracker;
        bit                live [SLOTS];
        logic [ADDR_W-1:0] addr [SLOTS];
        logic              console [SLOTS];
        logic [LIFE_W-1:0] life [SLOTS];
        logic [LIFE_W-1:0] timeout;
        reply_t            pending [$];
        int                errors;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                live[i] = 1'b0;
            end
            timeout = TIMEOUT_RST;
            errors = 0;
        endfunction

        function bit drop_entry(logic [ADDR_W-1:0] a);
            bit found;
            found = 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!found && live[i] && addr[i] == a)
                begin
                    live[i] = 1'b0;
                    found = 1'b1;
                end
            end
            return found;
        endfunction

        function void note_request(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] a, logic c);
            reply_t r;
            r.ok = 1'b0;
            r.cfg_present = 1'b0;
            if (kind == REQ_REGISTER)
            begin
                void'(drop_entry(a));
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!r.ok && !live[i])
                    begin
                        live[i] = 1'b1;
                        addr[i] = a;
                        console[i] = c;
                        life[i] = timeout;
                        r.ok = 1'b1;
                    end
                end
            end
            else if (kind == REQ_UNREGISTER)
            begin
                r.ok = drop_entry(a);
            end
            else if (kind == REQ_TICK)
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (live[i] && life[i] != '0)
                    begin
                        life[i] = life[i] - LIFE_W'(1);
                        if (life[i] == '0)
                            live[i] = 1'b0;
                    end
                end
            end
            for (int i = 0; i < SLOTS; i++)
            begin
                if (live[i] && console[i])
                    r.cfg_present = 1'b1;
            end
            pending.push_back(r);
        endfunction

        function void check_response(logic ok, logic cfg_present);
            reply_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected response beat, expected none,", $time,
                         " actual ok=%b cfg_present=%b", ok, cfg_present);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (ok !== want.ok)
            begin
                $display("%0t: ok mismatch, expected %b, actual %b", $time, want.ok, ok);
                errors++;
            end
            if (cfg_present !== want.cfg_present)
            begin
                $display("%0t: cfg_present mismatch, expected %b, actual %b",
                         $time, want.cfg_present, cfg_present);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ctau_req_if req_if ();
    ctau_rsp_if rsp_if ();
    ctau_cfg_if cfg_if ();

    client_table_with_aging_unit #(
        .MAX_CLIENTS(SLOTS)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if),
        .rsp  (rsp_if),
        .cfg  (cfg_if)
    );

    client_table_tracker tracker;
    int send_idle_pct;
    int stall_pct;
    int quiet_cycles;
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rsp_if.valid && rsp_if.ready)
            tracker.check_response(rsp_if.ok, rsp_if.cfg_present);
        rsp_if.ready <= rst_n && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] a,
                                input logic c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.req_type <= kind;
        req_if.client_addr <= a;
        req_if.is_cfg <= c;
        do
            @(posedge clk);
        while (!req_if.ready);
        tracker.note_request(kind, a, c);
    endtask

    task automatic wait_for_replies();
        req_if.valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_timeout(input logic [LIFE_W-1:0] value);
        wait_for_replies();
        cfg_if.valid <= 1'b1;
        cfg_if.connect_timeout <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        tracker.timeout = value;
    endtask

    function automatic logic [ADDR_W-1:0] pick_addr();
        if ($urandom_range(99) < 80)
            return addr_pool[$urandom_range(POOL_SIZE - 1)];
        return ADDR_W'({$urandom(), $urandom()});
    endfunction

    task automatic send_random_request();
        int roll;
        logic [REQ_W-1:0] kind;
        roll = $urandom_range(99);
        if (roll < 45)
            kind = REQ_REGISTER;
        else if (roll < 68)
            kind = REQ_UNREGISTER;
        else if (roll < 95)
            kind = REQ_TICK;
        else
            kind = REQ_UNUSED;
        send_request(kind, pick_addr(), 1'($urandom_range(1)));
    endtask

    initial
    begin
        logic [LIFE_W-1:0] timeouts [7];
        int idle_send [4];
        int idle_stall [4];
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_REGISTER;
        req_if.client_addr = '0;
        req_if.is_cfg = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.connect_timeout = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        tracker = new();
        timeouts = '{LIFE_W'(3), LIFE_W'(0), LIFE_W'(65535), LIFE_W'(1),
                     LIFE_W'(8), LIFE_W'(100), LIFE_W'(20)};
        idle_send = '{0, 61, 0, 6};
        idle_stall = '{0, 0, 61, 6};
        addr_pool[0] = '0;
        addr_pool[1] = ADDR_ONES;
        for (int i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = ADDR_W'({$urandom(), $urandom()});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(REQ_TICK, ADDR_ONES, 1'b1);
        send_request(REQ_UNREGISTER, '0, 1'b0);
        send_request(REQ_REGISTER, '0, 1'b1);
        send_request(REQ_REGISTER, ADDR_ONES, 1'b0);
        send_request(REQ_REGISTER, '0, 1'b0);
        for (int i = 1; i <= SLOTS - 2; i++)
            send_request(REQ_REGISTER, {8'(i), 40'hA5_5A3C_C300}, 1'b0);
        send_request(REQ_REGISTER, 48'h1234_5678_9ABC, 1'b1);
        send_request(REQ_REGISTER, ADDR_ONES, 1'b1);
        send_request(REQ_UNREGISTER, 48'h0BAD_0BAD_0BAD, 1'b0);
        send_request(REQ_UNREGISTER, '0, 1'b1);
        send_request(REQ_UNUSED, ADDR_ONES, 1'b1);
        send_request(REQ_TICK, '0, 1'b0);

        for (int p = 0; p < 7; p++)
        begin
            write_timeout(timeouts[p]);
            send_idle_pct = idle_send[p % 4];
            stall_pct = idle_stall[p % 4];
            for (int n = 0; n < 61; n++)
            begin
                send_random_request();
                if ($urandom_range(99) < 2)
                    wait_for_replies();
            end
        end

        wait_for_replies();
        stall_pct = 0;
        repeat (2 * SLOTS + 10) @(posedge clk);
        if (tracker.pending.size() != 0)
        begin
            $display("%0t: %0d response beats still expected", $time, tracker.pending.size());
            tracker.errors++;
        end
        if (tracker.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
